[hw/rtl/record_ring_buffer_writer_core_assert.svh]
// ---------------------------------------------------------------------------
// Record ring writer assertion macros
// Clocked assertion helpers used by the record ring writer job queue.
// ---------------------------------------------------------------------------
`ifndef RECORD_RING_BUFFER_WRITER_CORE_ASSERT_SVH
`define RECORD_RING_BUFFER_WRITER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Property that must hold at every rising edge out of reset.
`define RRBW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge out of reset.
`define RRBW_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define RRBW_ASSERT(label, prop, msg)
`define RRBW_NEVER(label, expr, msg)

`endif

`endif

[hw/rtl/rrbw_pkg.sv]
// ---------------------------------------------------------------------------
// Record ring writer package
// Sizes, codes, the job record and helper functions shared by the design.
// ---------------------------------------------------------------------------
package rrbw_pkg;

  localparam int RING_BYTES_LOG2 = 16;
  localparam int PAGE_BITS       = 12;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int WADDR_W         = 16;

  localparam logic [32:0] RING_BYTES  = 33'(1) << RING_BYTES_LOG2;
  localparam logic [31:0] RING_MASK   = 32'(RING_BYTES - 33'(1));
  localparam logic [31:0] MAX_RECORD  = 32'h3FFF_FFFF;
  localparam logic [31:0] BUSY_BIT    = 32'h8000_0000;
  localparam logic [7:0]  HPB_RESET   = 8'd3;

  typedef enum logic [1:0] {
    OP_BEGIN    = 2'd0,
    OP_PAYLOAD  = 2'd1,
    OP_CONSUMER = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_FLAGS = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_BAD_SEQ   = 3'd4
  } status_t;

  // One classified item: up to two ring writes, then the closing status beat.
  typedef struct packed {
    logic [1:0]         n_writes;
    logic [WADDR_W-1:0] addr0;
    logic [63:0]        data0;
    logic [WADDR_W-1:0] addr1;
    logic [63:0]        data1;
    status_t            status;
    logic               wake;
    logic [31:0]        prod;
    logic               avail;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [31:0] ring_off(input logic [31:0] pos);
    return pos & RING_MASK;
  endfunction

  function automatic logic [63:0] header_word(input logic [7:0] base,
                                              input logic [31:0] start,
                                              input logic [31:0] len);
    logic [31:0] pg;
    pg = 32'(base) + (ring_off(start) >> PAGE_BITS);
    return {pg, len};
  endfunction

endpackage

[hw/rtl/rrbw_in_if.sv]
// ---------------------------------------------------------------------------
// Record ring writer input channel
// Valid/ready channel carrying one command item per beat.
// ---------------------------------------------------------------------------
interface rrbw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] record_size;
  logic [7:0]  wake_flags;
  logic [63:0] payload_word;
  logic [31:0] consumer_position;

  modport source (
    output valid, operation, record_size, wake_flags, payload_word,
           consumer_position,
    input  ready
  );
  modport sink (
    input  valid, operation, record_size, wake_flags, payload_word,
           consumer_position,
    output ready
  );
endinterface

[hw/rtl/rrbw_out_if.sv]
// ---------------------------------------------------------------------------
// Record ring writer result channel
// Valid/ready channel carrying one ring write or status report per beat.
// ---------------------------------------------------------------------------
interface rrbw_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  status;
  logic [15:0] write_address;
  logic [63:0] write_data;
  logic        wakeup;
  logic [31:0] producer_position;
  logic        data_available;
  logic        last;

  modport source (
    output valid, result_kind, status, write_address, write_data, wakeup,
           producer_position, data_available, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, status, write_address, write_data, wakeup,
           producer_position, data_available, last,
    output ready
  );
endinterface

[hw/rtl/rrbw_front.sv]
// ---------------------------------------------------------------------------
// Record ring writer front end
// Accepts items, runs the reserve/commit checks and updates ring state.
// ---------------------------------------------------------------------------
module rrbw_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  rrbw_in_if.sink       in_ch,
  input  rrbw_pkg::q_stat_t q_stat,
  output logic          push,
  output rrbw_pkg::job_t job
);
  import rrbw_pkg::*;

  logic [7:0]  hpb_r;
  logic [31:0] prod_r, prod_nxt;
  logic [31:0] cons_r, cons_nxt;
  logic        open_r, open_nxt;
  logic [31:0] start_r, start_nxt;
  logic [29:0] bytes_r, bytes_nxt;
  logic [27:0] words_r, words_nxt;
  logic [1:0]  mode_r, mode_nxt;

  logic [32:0] len;
  logic [31:0] newp;
  logic [31:0] space;
  logic [30:0] total_w;
  logic [27:0] total;
  logic [27:0] wd_inc;
  logic [31:0] pay_addr;
  logic [31:0] prod_off;
  logic [31:0] start_off;
  logic [63:0] keep_mask;
  logic        wake_begin;
  logic        wake_pay;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  // Ring offsets of the producer and of the open record's header
  assign prod_off  = ring_off(prod_r);
  assign start_off = ring_off(start_r);

  // Begin checks
  assign len   = (33'(in_ch.record_size) + 33'd15) & ~33'd7;
  assign newp  = prod_r + len[31:0];
  assign space = newp - cons_r;
  assign wake_begin = in_ch.wake_flags[1] ||
                      ((ring_off(cons_r) == ring_off(prod_r)) && !in_ch.wake_flags[0]);

  // Payload bookkeeping
  assign total_w  = {1'b0, bytes_r} + 31'd7;
  assign total    = total_w[30:3];
  assign wd_inc   = words_r + 28'd1;
  assign pay_addr = ring_off(start_r + 32'd8 + 32'({words_r, 3'b000}));
  assign keep_mask = (bytes_r[2:0] == 3'd0) ? '1 :
                     ((64'd1 << {bytes_r[2:0], 3'b000}) - 64'd1);
  assign wake_pay = mode_r[1] ||
                    ((ring_off(cons_r) == ring_off(start_r)) && !mode_r[0]);

  always_comb begin
    prod_nxt  = prod_r;
    cons_nxt  = cons_r;
    open_nxt  = open_r;
    start_nxt = start_r;
    bytes_nxt = bytes_r;
    words_nxt = words_r;
    mode_nxt  = mode_r;

    job          = '0;
    job.status   = ST_OK;

    case (op_t'(in_ch.operation))
      OP_CONSUMER: begin
        cons_nxt = in_ch.consumer_position;
      end
      OP_BEGIN: begin
        if (open_r) begin
          job.status = ST_BAD_SEQ;
        end else if (in_ch.wake_flags[7:2] != 6'd0) begin
          job.status = ST_BAD_FLAGS;
        end else if (in_ch.record_size > MAX_RECORD) begin
          job.status = ST_TOO_LARGE;
        end else if (len > RING_BYTES) begin
          job.status = ST_TOO_LARGE;
        end else if (space > RING_MASK) begin
          job.status = ST_NO_SPACE;
        end else begin
          start_nxt  = prod_r;
          bytes_nxt  = in_ch.record_size[29:0];
          words_nxt  = '0;
          mode_nxt   = in_ch.wake_flags[1:0];
          prod_nxt   = newp;
          job.addr0  = prod_off[WADDR_W-1:0];
          job.data0  = header_word(hpb_r, prod_r, in_ch.record_size | BUSY_BIT);
          if (in_ch.record_size == 32'd0) begin
            // Empty record: commit straight away
            open_nxt     = 1'b0;
            job.n_writes = 2'd2;
            job.addr1    = prod_off[WADDR_W-1:0];
            job.data1    = header_word(hpb_r, prod_r, 32'd0);
            job.wake     = wake_begin;
          end else begin
            open_nxt     = 1'b1;
            job.n_writes = 2'd1;
          end
        end
      end
      OP_PAYLOAD: begin
        if (!open_r) begin
          job.status = ST_BAD_SEQ;
        end else begin
          words_nxt = wd_inc;
          job.addr0 = pay_addr[WADDR_W-1:0];
          if (wd_inc >= total) begin
            open_nxt     = 1'b0;
            job.n_writes = 2'd2;
            job.data0    = in_ch.payload_word & keep_mask;
            job.addr1    = start_off[WADDR_W-1:0];
            job.data1    = header_word(hpb_r, start_r, {2'b00, bytes_r});
            job.wake     = wake_pay;
          end else begin
            job.n_writes = 2'd1;
            job.data0    = in_ch.payload_word;
          end
        end
      end
      default: begin
        job.status = ST_BAD_SEQ;
      end
    endcase

    job.prod  = prod_nxt;
    job.avail = (prod_nxt != cons_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpb_r   <= HPB_RESET;
      prod_r  <= '0;
      cons_r  <= '0;
      open_r  <= 1'b0;
      start_r <= '0;
      bytes_r <= '0;
      words_r <= '0;
      mode_r  <= '0;
    end else begin
      if (cfg_we) begin
        hpb_r <= cfg_wdata;
      end
      if (push) begin
        prod_r  <= prod_nxt;
        cons_r  <= cons_nxt;
        open_r  <= open_nxt;
        start_r <= start_nxt;
        bytes_r <= bytes_nxt;
        words_r <= words_nxt;
        mode_r  <= mode_nxt;
      end
    end
  end

endmodule

[hw/rtl/rrbw_queue.sv]
// ---------------------------------------------------------------------------
// Record ring writer job queue
// Short FIFO of classified jobs between the front and back ends.
// ---------------------------------------------------------------------------
`include "record_ring_buffer_writer_core_assert.svh"

module rrbw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rrbw_pkg::job_t    push_job,
  input  logic              pop,
  output rrbw_pkg::job_t    head,
  output rrbw_pkg::q_stat_t q_stat
);
  import rrbw_pkg::*;

  job_t                   mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                   wr_ptr_r + QUEUE_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                   rd_ptr_r + QUEUE_PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QUEUE_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `RRBW_NEVER(a_q_no_overflow, push && q_stat.full, "job queue written while full")
  `RRBW_NEVER(a_q_no_underflow, pop && q_stat.empty, "job queue popped while empty")
  `RRBW_ASSERT(a_q_count_up, (push && !pop) |=> (count_r == $past(count_r) + 1'b1), "queue count did not rise")
  `RRBW_NEVER(a_q_count_range, count_r > QUEUE_CNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

[hw/rtl/rrbw_back.sv]
// ---------------------------------------------------------------------------
// Record ring writer back end
// Plays out each job as its ring writes followed by one status beat.
// ---------------------------------------------------------------------------
module rrbw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rrbw_pkg::job_t    head,
  input  rrbw_pkg::q_stat_t q_stat,
  output logic              pop,
  rrbw_out_if.source        out_ch
);
  import rrbw_pkg::*;

  logic [1:0] beat_r, beat_nxt;
  logic       is_write;
  logic       take;

  assign is_write = (beat_r < head.n_writes);
  assign take     = out_ch.valid && out_ch.ready;
  assign pop      = take && !is_write;

  assign out_ch.valid             = !q_stat.empty;
  assign out_ch.result_kind       = is_write;
  assign out_ch.status            = is_write ? ST_OK : head.status;
  assign out_ch.write_address     = !is_write ? '0 :
                                    (beat_r == 2'd0) ? head.addr0 : head.addr1;
  assign out_ch.write_data        = !is_write ? '0 :
                                    (beat_r == 2'd0) ? head.data0 : head.data1;
  assign out_ch.wakeup            = !is_write && head.wake;
  assign out_ch.producer_position = head.prod;
  assign out_ch.data_available    = head.avail;
  assign out_ch.last              = !is_write;

  // Advance on each taken write beat, rewind after the status beat
  always_comb begin
    beat_nxt = beat_r;
    if (take) begin
      beat_nxt = is_write ? beat_r + 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

endmodule

[hw/rtl/record_ring_buffer_writer_core.sv]
// ---------------------------------------------------------------------------
// Record ring writer core
// Reserve/commit writer of variable-length records into a byte ring.
// ---------------------------------------------------------------------------
//
//  channel  | dir | beat
//  ---------+-----+------------------------------------------------------
//  in_ch    | in  | begin record, payload word or consumer position
//  out_ch   | out | ring write (header or payload) or closing status report
//  cfg_*    | in  | header_page_base write, no read-back
//
//  The front end takes one item per cycle whenever the job queue has room.
//  Each item leaves as one to three result beats, one beat per cycle while
//  out_ch is ready; the two-entry job queue lets the front end carry on
//  while the result side plays out an item.
//  Reset (rst_n low, synchronous) clears positions, the open record and the
//  queue, and loads header_page_base with three.
//  A stall on out_ch fills the queue and then drops in_ch.ready.
//
module record_ring_buffer_writer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  rrbw_in_if.sink     in_ch,
  rrbw_out_if.source  out_ch
);
  import rrbw_pkg::*;

  // Front to queue
  logic    push;
  job_t    new_job;

  // Queue to back
  job_t    head_job;
  q_stat_t q_stat;
  logic    pop;

  // Classify items, hold ring state and the page base register
  rrbw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .job       (new_job)
  );

  // Decouple the two sides
  rrbw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (new_job),
    .pop      (pop),
    .head     (head_job),
    .q_stat   (q_stat)
  );

  // Emit writes then the status beat for each job
  rrbw_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head_job),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

[tb/ring_write_checker.sv]
// ---------------------------------------------------------------------------
// Record ring writer result checker
// Watches the command, result and register ports, predicts every result beat
// of the ring writer from its own copy of the ring state and compares each
// accepted beat, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module ring_write_checker
  import rrbw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  rrbw_in_if         in_ch,
  rrbw_out_if        out_ch,
  output int         failures,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [15:0] addr;
    logic [63:0] data;
    logic        wake;
    logic [31:0] prod;
    logic        avail;
    logic        last;
  } ring_beat_t;

  ring_beat_t  pending_ring_beats[$];

  // Shadow of the writer state.
  logic [7:0]  page_base;
  logic [31:0] shadow_prod;
  logic [31:0] shadow_cons;
  logic [31:0] rec_start;
  logic [31:0] rec_bytes;
  logic        rec_open;
  logic [27:0] words_in;
  logic [1:0]  rec_wake;

  initial failures = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    failures++;
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic void push_beat(input logic kind, input status_t st,
                                    input logic [31:0] addr, input logic [63:0] data,
                                    input logic wake, input logic fin);
    ring_beat_t b;
    b.kind   = kind;
    b.status = st;
    b.addr   = addr[15:0];
    b.data   = data;
    b.wake   = wake;
    b.prod   = shadow_prod;
    b.avail  = (shadow_prod != shadow_cons);
    b.last   = fin;
    pending_ring_beats.push_back(b);
  endfunction

  function automatic void report_status(input status_t st);
    push_beat(1'b0, st, '0, '0, 1'b0, 1'b1);
  endfunction

  function automatic logic [63:0] header_of(input logic [31:0] len);
    logic [31:0] page;
    page = 32'(page_base) + ((rec_start & RING_MASK) >> PAGE_BITS);
    return {page, len};
  endfunction

  // Rewrite the header without busy, then close with the wake decision.
  function automatic void commit_record();
    logic wake;
    push_beat(1'b1, ST_OK, rec_start & RING_MASK, header_of(rec_bytes), 1'b0, 1'b0);
    wake = rec_wake[1] ||
           (((shadow_cons & RING_MASK) == (rec_start & RING_MASK)) && !rec_wake[0]);
    rec_open = 1'b0;
    push_beat(1'b0, ST_OK, '0, '0, wake, 1'b1);
  endfunction

  function automatic void predict_ring_beats(input logic [1:0] op,
                                             input logic [31:0] size,
                                             input logic [7:0] flags,
                                             input logic [63:0] word,
                                             input logic [31:0] cpos);
    logic [32:0] len;
    logic [31:0] next_prod;
    logic [31:0] total;
    logic [31:0] addr;
    logic [63:0] data;
    case (op_t'(op))
      OP_CONSUMER: begin
        shadow_cons = cpos;
        report_status(ST_OK);
      end
      OP_BEGIN: begin
        len       = (33'(size) + 33'd15) & ~33'd7;
        next_prod = shadow_prod + len[31:0];
        if (rec_open) begin
          report_status(ST_BAD_SEQ);
        end else if (flags[7:2] != '0) begin
          report_status(ST_BAD_FLAGS);
        end else if (size > MAX_RECORD || len > 33'(RING_MASK) + 33'd1) begin
          report_status(ST_TOO_LARGE);
        end else if (next_prod - shadow_cons > RING_MASK) begin
          report_status(ST_NO_SPACE);
        end else begin
          rec_start   = shadow_prod;
          rec_bytes   = size;
          words_in    = '0;
          rec_wake    = flags[1:0];
          rec_open    = 1'b1;
          shadow_prod = next_prod;
          push_beat(1'b1, ST_OK, rec_start & RING_MASK, header_of(size | BUSY_BIT),
                    1'b0, 1'b0);
          if (size == '0) commit_record();
          else report_status(ST_OK);
        end
      end
      OP_PAYLOAD: begin
        if (!rec_open) begin
          report_status(ST_BAD_SEQ);
        end else begin
          total    = (rec_bytes + 32'd7) >> 3;
          addr     = (rec_start + 32'd8 + (32'(words_in) << 3)) & RING_MASK;
          words_in = words_in + 28'd1;
          data     = word;
          if (32'(words_in) >= total) begin
            // zero the bytes past the end of a partial final word
            if (rec_bytes[2:0] != '0)
              data &= (64'd1 << {rec_bytes[2:0], 3'b000}) - 64'd1;
            push_beat(1'b1, ST_OK, addr, data, 1'b0, 1'b0);
            commit_record();
          end else begin
            push_beat(1'b1, ST_OK, addr, data, 1'b0, 1'b0);
            report_status(ST_OK);
          end
        end
      end
      default: report_status(ST_BAD_SEQ);
    endcase
  endfunction

  always @(posedge clk) begin : watch
    ring_beat_t seen;
    ring_beat_t want;
    if (!rst_n) begin
      page_base   = HPB_RESET;
      shadow_prod = '0;
      shadow_cons = '0;
      rec_start   = '0;
      rec_bytes   = '0;
      rec_open    = 1'b0;
      words_in    = '0;
      rec_wake    = '0;
      pending_ring_beats.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_ring_beats(in_ch.operation, in_ch.record_size, in_ch.wake_flags,
                           in_ch.payload_word, in_ch.consumer_position);
      if (cfg_we)
        page_base = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        seen.kind   = out_ch.result_kind;
        seen.status = status_t'(out_ch.status);
        seen.addr   = out_ch.write_address;
        seen.data   = out_ch.write_data;
        seen.wake   = out_ch.wakeup;
        seen.prod   = out_ch.producer_position;
        seen.avail  = out_ch.data_available;
        seen.last   = out_ch.last;
        if (pending_ring_beats.size() == 0) begin
          report_mismatch("unexpected result beat, write_data", seen.data, '0);
        end else begin
          want = pending_ring_beats.pop_front();
          if (seen.kind != want.kind)
            report_mismatch("result_kind", 64'(seen.kind), 64'(want.kind));
          if (seen.status != want.status)
            report_mismatch("status", 64'(seen.status), 64'(want.status));
          if (seen.addr != want.addr)
            report_mismatch("write_address", 64'(seen.addr), 64'(want.addr));
          if (seen.data != want.data)
            report_mismatch("write_data", seen.data, want.data);
          if (seen.wake != want.wake)
            report_mismatch("wakeup", 64'(seen.wake), 64'(want.wake));
          if (seen.prod != want.prod)
            report_mismatch("producer_position", 64'(seen.prod), 64'(want.prod));
          if (seen.avail != want.avail)
            report_mismatch("data_available", 64'(seen.avail), 64'(want.avail));
          if (seen.last != want.last)
            report_mismatch("last", 64'(seen.last), 64'(want.last));
        end
      end
    end
    outstanding <= pending_ring_beats.size();
  end

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// Record ring writer testbench
// Drives begin, payload and consumer beats into the ring writer, with random
// idling on both channels, and lets the result checker beside the block judge
// every result beat. A directed opening covers every status and wake case,
// one longer record mixes noise into its payload, and random record traffic
// then runs under several page base settings.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rrbw_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int failures;
  int outstanding;
  int sent;

  // Stimulus-side view of the ring: where the next header lands (head) and
  // the last consumer position reported (tail).
  logic [31:0] head;
  logic [31:0] tail;

  // Set for a stretch with no idling on either side.
  bit calm;

  rrbw_in_if  in_ch ();
  rrbw_out_if out_ch ();

  record_ring_buffer_writer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ring_write_checker ring_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Result side: stall about a quarter of the cycles unless running calm.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // Offer one beat, idling first at random, and hold it until it is taken.
  // Valid stays high afterwards so the next beat can follow back to back.
  task automatic send_item(input op_t op, input logic [31:0] size,
                           input logic [7:0] flags, input logic [63:0] word,
                           input logic [31:0] cpos);
    while (!calm && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.operation         <= op;
    in_ch.record_size       <= size;
    in_ch.wake_flags        <= flags;
    in_ch.payload_word      <= word;
    in_ch.consumer_position <= cpos;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic set_reader(input logic [31:0] pos);
    tail = pos;
    send_item(OP_CONSUMER, $urandom(), 8'($urandom_range(255)), random_word(), pos);
  endtask

  // Drop valid and hold off until every predicted beat has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_page_base(input logic [7:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Begin a record and, when it fits, fill it with random payload. With noisy
  // set, mix consumer moves, stray begins and unused codes into the payload.
  task automatic put_record(input logic [31:0] size, input logic [1:0] flags,
                            input bit noisy);
    logic [32:0] len;
    logic [31:0] start;
    int          words;
    bit          fits;
    len   = (33'(size) + 33'd15) & ~33'd7;
    start = head;
    fits  = (size <= 32'd65528) && (head + len[31:0] - tail <= 32'h0000_FFFF);
    send_item(OP_BEGIN, size, {6'b0, flags}, random_word(), $urandom());
    if (fits) begin
      head  = head + len[31:0];
      words = int'((size + 32'd7) >> 3);
      for (int i = 0; i < words; i++) begin
        if (noisy && $urandom_range(99) < 8) begin
          case ($urandom_range(3))
            0: set_reader(start);                          // reader parks on this record
            1: set_reader(head - $urandom_range(0, 4096));
            2: send_item(OP_BEGIN, $urandom(), 8'($urandom_range(255)), random_word(),
                         $urandom());                      // begin while open
            default: send_item(OP_UNUSED, $urandom(), 8'($urandom_range(255)),
                               random_word(), $urandom());
          endcase
        end
        send_item(OP_PAYLOAD, $urandom(), 8'($urandom_range(255)), random_word(),
                  $urandom());
      end
    end
  endtask

  // Mostly well-formed records of small size; the rest is noise that leaves
  // the ring untouched, plus the odd drain to empty the pipeline mid-run.
  task automatic random_traffic(input int n);
    int          stop_at;
    int          pick;
    logic [31:0] size;
    stop_at = sent + n;
    while (sent < stop_at) begin
      if ($urandom_range(99) < 70) begin
        case ($urandom_range(9))
          0, 1, 2: set_reader(head);                      // reader caught up
          3, 4:    set_reader(head - $urandom_range(0, 65535));
          5:       set_reader($urandom());
          default: ;
        endcase
        pick = $urandom_range(99);
        if (pick < 10)      size = '0;
        else if (pick < 80) size = $urandom_range(1, 64);
        else if (pick < 96) size = $urandom_range(65, 400);
        else                size = $urandom_range(401, 1024);
        put_record(size, 2'($urandom_range(3)), 1'b1);
      end else begin
        case ($urandom_range(5))
          0: send_item(OP_PAYLOAD, $urandom(), 8'($urandom_range(255)), random_word(),
                       $urandom());                        // no record open
          1: send_item(OP_UNUSED, $urandom(), 8'($urandom_range(255)), random_word(),
                       $urandom());
          2: send_item(OP_BEGIN, $urandom(), 8'($urandom_range(4, 255)), random_word(),
                       $urandom());                        // invalid flag bits
          3: send_item(OP_BEGIN, $urandom_range(65529, 32'hFFFF_FFFF),
                       8'($urandom_range(3)), random_word(), $urandom());  // oversize
          4: send_item(OP_BEGIN, $urandom_range(65529, 32'hFFFF_FFFF),
                       8'($urandom_range(255)), random_word(), $urandom());
          default: drain_results();
        endcase
      end
    end
  endtask

  initial begin
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_wdata               <= '0;
    in_ch.valid             <= 1'b0;
    in_ch.operation         <= OP_BEGIN;
    in_ch.record_size       <= '0;
    in_ch.wake_flags        <= '0;
    in_ch.payload_word      <= '0;
    in_ch.consumer_position <= '0;
    head = '0;
    tail = '0;
    calm = 1'b0;
    sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening, page base still at its reset value.
    // Out-of-sequence beats and the unused code with every field at its top.
    send_item(OP_PAYLOAD, '1, '1, '1, '1);
    send_item(OP_UNUSED, '1, '1, '1, '1);
    // Invalid flags, also checked ahead of an oversize record.
    send_item(OP_BEGIN, 32'd8, 8'hFC, '0, '0);
    send_item(OP_BEGIN, 32'hFFFF_FFFF, 8'h04, '0, '0);
    // Oversize: above the record limit, just above it, at it, and just past the ring.
    send_item(OP_BEGIN, 32'hFFFF_FFFF, 8'h00, '0, '0);
    send_item(OP_BEGIN, 32'h4000_0000, 8'h00, '0, '0);
    send_item(OP_BEGIN, MAX_RECORD, 8'h03, '0, '0);
    send_item(OP_BEGIN, 32'd65529, 8'h00, '0, '0);
    // A record of the full ring length can never find room.
    send_item(OP_BEGIN, 32'd65528, 8'h00, '0, '0);
    // Reader far ahead: a small record finds no space either.
    set_reader(32'h0001_0000);
    send_item(OP_BEGIN, 32'd8, 8'h00, '0, '0);
    // Empty record with the reader on it: header, final header, wake.
    set_reader(32'd0);
    put_record(32'd0, 2'b00, 1'b0);
    // Reader on the record but wakeup suppressed.
    set_reader(32'd8);
    put_record(32'd0, 2'b01, 1'b0);
    // Both wake bits: force wins; five bytes leave a partial final word.
    put_record(32'd5, 2'b11, 1'b0);
    // Two-word record with a stray begin and a consumer move while open.
    set_reader(32'd32);
    send_item(OP_BEGIN, 32'd16, 8'h00, '1, '1);
    head = 32'd56;
    send_item(OP_PAYLOAD, '0, '0, '0, '0);
    send_item(OP_BEGIN, 32'd8, 8'h00, '0, '0);
    set_reader(32'd32);
    send_item(OP_PAYLOAD, '1, '1, '1, '1);
    // One payload too many.
    send_item(OP_PAYLOAD, '0, '0, 64'h0123_4567_89AB_CDEF, '0);

    // Top page base, then one longer record with noise mixed into its payload.
    write_page_base(8'hFF);
    set_reader(head);
    put_record(32'd480, 2'b00, 1'b1);

    // Bottom page base, random traffic with a stretch of no idling.
    write_page_base(8'h00);
    random_traffic(100);
    calm = 1'b1;
    random_traffic(80);
    calm = 1'b0;

    // A middling page base for the rest.
    write_page_base(8'($urandom_range(1, 254)));
    random_traffic(100);

    // Let the pipeline empty, then a short grace period for stray beats.
    drain_results();
    repeat (10) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
